// ===== src/tevq_pkg.sv =====
package tevq_pkg;

    localparam int CAPACITY     = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int SLOT_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    localparam int REQ_W   = 2;
    localparam int ID_W    = 16;
    localparam int DELAY_W = 16;
    localparam int TIME_W  = 32;
    localparam int THR_W   = 16;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ   = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef struct packed {
        logic capture;
        logic enq_exec;
        logic clr_exec;
        logic emit_empty;
        logic scan_clear;
        logic scan_step;
        logic finish_emit;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic out_free;
        logic step_blocked;
        logic scan_last;
    } stat_t;

endpackage

// ===== src/tevq_datapath.sv =====
module tevq_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tevq_pkg::cmd_t                cmd,
    output tevq_pkg::stat_t               stat,
    input  logic                          cfg_valid,
    input  logic [tevq_pkg::THR_W-1:0]    cfg_instant_threshold,
    input  logic [tevq_pkg::REQ_W-1:0]    s_req_type,
    input  logic [tevq_pkg::ID_W-1:0]     s_event_id,
    input  logic [tevq_pkg::DELAY_W-1:0]  s_delay_ms,
    input  logic [tevq_pkg::TIME_W-1:0]   s_now_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_published,
    output logic [tevq_pkg::ID_W-1:0]     m_out_event_id,
    output logic                          m_status,
    output logic                          m_last
);
    import tevq_pkg::*;

    logic [THR_W-1:0]   thr_reg;
    req_t               req_reg;
    logic [ID_W-1:0]    id_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [CAPACITY-1:0] valid_reg;
    logic [TIME_W-1:0]   expiry_mem [CAPACITY];
    logic [ID_W-1:0]     event_mem  [CAPACITY];

    logic [SLOT_W-1:0] idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ID_W-1:0]   held_reg;
    logic              held_valid_reg;

    logic              m_valid_reg;
    logic              pub_reg;
    logic [ID_W-1:0]   oid_reg;
    logic              status_reg;
    logic              last_reg;

    logic              out_free;
    logic              immediate;
    logic              full;
    logic [SLOT_W-1:0] free_idx;
    logic              hit;
    logic [CNT_W-1:0]  cnt_next;
    logic              do_store;

    logic              load;
    logic              pub_next;
    logic [ID_W-1:0]   oid_next;
    logic              status_next;
    logic              last_next;

    assign out_free  = !m_valid_reg || m_ready;
    assign immediate = {{(THR_W-DELAY_W){1'b0}}, delay_reg} < thr_reg;
    assign full      = &valid_reg;
    assign do_store  = cmd.enq_exec && !immediate && !full;
    assign hit       = valid_reg[idx_reg] && (expiry_mem[idx_reg] < now_reg);
    assign cnt_next  = cnt_reg + CNT_W'(1);

    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        stat.req          = req_reg;
        stat.out_free     = out_free;
        stat.step_blocked = hit && held_valid_reg && !out_free;
        stat.scan_last    = (idx_reg == SLOT_W'(CAPACITY - 1)) ||
                            (hit && cnt_next == CNT_W'(RESULT_LIMIT));
    end

    always_comb begin
        load        = 1'b0;
        pub_next    = 1'b0;
        oid_next    = '0;
        status_next = 1'b0;
        last_next   = 1'b1;
        if (cmd.enq_exec) begin
            load = 1'b1;
            if (immediate) begin
                pub_next = 1'b1;
                oid_next = id_reg;
            end else if (full) begin
                status_next = 1'b1;
            end
        end else if (cmd.clr_exec || cmd.emit_empty) begin
            load = 1'b1;
        end else if (cmd.scan_step && hit && held_valid_reg) begin
            load      = 1'b1;
            pub_next  = 1'b1;
            oid_next  = held_reg;
            last_next = 1'b0;
        end else if (cmd.finish_emit) begin
            load     = 1'b1;
            pub_next = held_valid_reg;
            oid_next = held_valid_reg ? held_reg : '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= THR_RESET;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            req_reg        <= REQ_NONE;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_instant_threshold;
            end
            if (cmd.capture) begin
                req_reg <= req_t'(s_req_type);
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.clr_exec) begin
                valid_reg <= '0;
            end else if (do_store) begin
                valid_reg[free_idx] <= 1'b1;
            end else if (cmd.scan_step && hit) begin
                valid_reg[idx_reg] <= 1'b0;
            end
            if (cmd.scan_clear) begin
                idx_reg        <= '0;
                cnt_reg        <= '0;
                held_valid_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                idx_reg <= idx_reg + SLOT_W'(1);
                if (hit) begin
                    cnt_reg        <= cnt_next;
                    held_valid_reg <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            id_reg    <= s_event_id;
            delay_reg <= s_delay_ms;
            now_reg   <= s_now_ms;
        end
        if (do_store) begin
            expiry_mem[free_idx] <= now_reg + {{(TIME_W-DELAY_W){1'b0}}, delay_reg};
            event_mem[free_idx]  <= id_reg;
        end
        if (cmd.scan_step && hit) begin
            held_reg <= event_mem[idx_reg];
        end
        if (load) begin
            pub_reg    <= pub_next;
            oid_reg    <= oid_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_published    = pub_reg;
    assign m_out_event_id = oid_reg;
    assign m_status       = status_reg;
    assign m_last         = last_reg;

endmodule

// ===== src/tevq_ctrl.sv =====
module tevq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tevq_pkg::stat_t  stat,
    output tevq_pkg::cmd_t   cmd
);
    import tevq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.req == REQ_TICK) begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end else if (stat.out_free) begin
                    state_next = ST_IDLE;
                    case (stat.req)
                        REQ_ENQ:   cmd.enq_exec   = 1'b1;
                        REQ_CLEAR: cmd.clr_exec   = 1'b1;
                        default:   cmd.emit_empty = 1'b1;
                    endcase
                end
            end
            ST_SCAN: begin
                if (!stat.step_blocked) begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish_emit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/timed_event_queue.sv =====
// channel   | direction | handshake            | payload
// s_        | in        | s_valid / s_ready    | req_type, event_id, delay_ms, now_ms
// m_        | out       | m_valid / m_ready    | published, out_event_id, status, last
// cfg_      | in        | cfg_valid / cfg_ready| instant_threshold
//
// enqueue, clear and unused codes: one result once the result register is free, then idle
// tick: one slot compared per cycle while the output does not stall the scan, up to the
// last slot or the result limit; idle again as the last result is placed
// synchronous active-low reset empties the store and sets the threshold to 1
// m_ready low holds the result register and stalls the slot scan on a second hit
module timed_event_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tevq_pkg::THR_W-1:0]    cfg_instant_threshold,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tevq_pkg::REQ_W-1:0]    s_req_type,
    input  logic [tevq_pkg::ID_W-1:0]     s_event_id,
    input  logic [tevq_pkg::DELAY_W-1:0]  s_delay_ms,
    input  logic [tevq_pkg::TIME_W-1:0]   s_now_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_published,
    output logic [tevq_pkg::ID_W-1:0]     m_out_event_id,
    output logic                          m_status,
    output logic                          m_last
);
    import tevq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    tevq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tevq_datapath u_datapath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .stat                  (stat),
        .cfg_valid             (cfg_valid),
        .cfg_instant_threshold (cfg_instant_threshold),
        .s_req_type            (s_req_type),
        .s_event_id            (s_event_id),
        .s_delay_ms            (s_delay_ms),
        .s_now_ms              (s_now_ms),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_published           (m_published),
        .m_out_event_id        (m_out_event_id),
        .m_status              (m_status),
        .m_last                (m_last)
    );

endmodule

// ===== tb/timed_event_queue_check.sv =====
`timescale 1ns / 100ps

module timed_event_queue_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tevq_pkg::THR_W-1:0]    cfg_instant_threshold,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [tevq_pkg::REQ_W-1:0]    s_req_type,
    input  logic [tevq_pkg::ID_W-1:0]     s_event_id,
    input  logic [tevq_pkg::DELAY_W-1:0]  s_delay_ms,
    input  logic [tevq_pkg::TIME_W-1:0]   s_now_ms,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_published,
    input  logic [tevq_pkg::ID_W-1:0]     m_out_event_id,
    input  logic                          m_status,
    input  logic                          m_last,
    output int                            error_count,
    output int                            pending,
    output int                            checked_count,
    output int                            published_count,
    output int                            refused_count
);
    import tevq_pkg::*;

    typedef struct packed {
        logic            published;
        logic [ID_W-1:0] event_id;
        logic            status;
        logic            last;
    } outcome_t;

    outcome_t          awaited_outcomes[$];
    outcome_t          want;
    logic [THR_W-1:0]  threshold;
    logic              slot_busy   [CAPACITY];
    logic [TIME_W-1:0] slot_expiry [CAPACITY];
    logic [ID_W-1:0]   slot_event  [CAPACITY];

    initial begin
        error_count     = 0;
        pending         = 0;
        checked_count   = 0;
        published_count = 0;
        refused_count   = 0;
    end

    function automatic outcome_t make_outcome(logic published, logic [ID_W-1:0] event_id,
                                              logic status, logic last);
        outcome_t o;
        o.published = published;
        o.event_id  = event_id;
        o.status    = status;
        o.last      = last;
        return o;
    endfunction

    function automatic void compare_field(string field, int unsigned exp_val,
                                          int unsigned act_val);
        if (exp_val != act_val) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
        end
    endfunction

    // model of the store: works out the results of one accepted request
    task automatic predict_outcomes(req_t req, logic [ID_W-1:0] event_id,
                                    logic [DELAY_W-1:0] delay, logic [TIME_W-1:0] now);
        int       free_slot;
        int       hits;
        outcome_t held;
        case (req)
            REQ_ENQ: begin
                if (delay < threshold) begin
                    awaited_outcomes.push_back(make_outcome(1'b1, event_id, 1'b0, 1'b1));
                    published_count++;
                end else begin
                    free_slot = -1;
                    for (int i = CAPACITY - 1; i >= 0; i--)
                        if (!slot_busy[i]) free_slot = i;
                    if (free_slot < 0) begin
                        awaited_outcomes.push_back(make_outcome(1'b0, '0, 1'b1, 1'b1));
                        refused_count++;
                    end else begin
                        slot_busy[free_slot]   = 1'b1;
                        slot_expiry[free_slot] = now + TIME_W'(delay);
                        slot_event[free_slot]  = event_id;
                        awaited_outcomes.push_back(make_outcome(1'b0, '0, 1'b0, 1'b1));
                    end
                end
            end
            REQ_TICK: begin
                hits = 0;
                held = '0;
                for (int i = 0; i < CAPACITY && hits < RESULT_LIMIT; i++) begin
                    if (slot_busy[i] && slot_expiry[i] < now) begin
                        if (hits > 0) awaited_outcomes.push_back(held);
                        held = make_outcome(1'b1, slot_event[i], 1'b0, 1'b0);
                        slot_busy[i] = 1'b0;
                        hits++;
                        published_count++;
                    end
                end
                if (hits == 0) begin
                    awaited_outcomes.push_back(make_outcome(1'b0, '0, 1'b0, 1'b1));
                end else begin
                    held.last = 1'b1;
                    awaited_outcomes.push_back(held);
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < CAPACITY; i++) slot_busy[i] = 1'b0;
                awaited_outcomes.push_back(make_outcome(1'b0, '0, 1'b0, 1'b1));
            end
            default: begin
                awaited_outcomes.push_back(make_outcome(1'b0, '0, 1'b0, 1'b1));
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            threshold = THR_RESET;
            for (int i = 0; i < CAPACITY; i++) slot_busy[i] = 1'b0;
            awaited_outcomes.delete();
        end else begin
            if (m_valid && m_ready) begin
                checked_count++;
                if (awaited_outcomes.size() == 0) begin
                    error_count++;
                    $display({"%0t ns: unexpected result, expected none, ",
                              "actual pub %0b id 0x%0h status %0b last %0b"},
                             $time, m_published, m_out_event_id, m_status, m_last);
                end else begin
                    want = awaited_outcomes.pop_front();
                    compare_field("published", want.published, m_published);
                    compare_field("out_event_id", want.event_id, m_out_event_id);
                    compare_field("status", want.status, m_status);
                    compare_field("last", want.last, m_last);
                end
            end
            if (cfg_valid && cfg_ready)
                threshold = cfg_instant_threshold;
            if (s_valid && s_ready)
                predict_outcomes(req_t'(s_req_type), s_event_id, s_delay_ms, s_now_ms);
        end
        pending <= awaited_outcomes.size();
    end

endmodule

// ===== tb/timed_event_queue_test.sv =====
`timescale 1ns / 100ps

module timed_event_queue_test;
    import tevq_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = CAPACITY + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 55;
    localparam int PHASES       = 6;

    logic               aclk                  = 1'b0;
    logic               aresetn               = 1'b0;
    logic               cfg_valid             = 1'b0;
    logic               cfg_ready;
    logic [THR_W-1:0]   cfg_instant_threshold = THR_RESET;
    logic               s_valid               = 1'b0;
    logic               s_ready;
    logic [REQ_W-1:0]   s_req_type            = REQ_NONE;
    logic [ID_W-1:0]    s_event_id            = '0;
    logic [DELAY_W-1:0] s_delay_ms            = '0;
    logic [TIME_W-1:0]  s_now_ms              = '0;
    logic               m_valid;
    logic               m_ready               = 1'b0;
    logic               m_published;
    logic [ID_W-1:0]    m_out_event_id;
    logic               m_status;
    logic               m_last;

    int                 error_count;
    int                 pending;
    int                 checked_count;
    int                 published_count;
    int                 refused_count;

    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    logic               hold_armed     = 1'b0;
    logic               hold_done      = 1'b0;
    int                 hold_left      = 0;
    int                 cycle_count    = 0;
    int                 request_count  = 0;
    logic [TIME_W-1:0]  sim_ms         = '0;

    timed_event_queue u_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_instant_threshold (cfg_instant_threshold),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_req_type            (s_req_type),
        .s_event_id            (s_event_id),
        .s_delay_ms            (s_delay_ms),
        .s_now_ms              (s_now_ms),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_published           (m_published),
        .m_out_event_id        (m_out_event_id),
        .m_status              (m_status),
        .m_last                (m_last)
    );

    timed_event_queue_check u_check (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_instant_threshold (cfg_instant_threshold),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_req_type            (s_req_type),
        .s_event_id            (s_event_id),
        .s_delay_ms            (s_delay_ms),
        .s_now_ms              (s_now_ms),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_published           (m_published),
        .m_out_event_id        (m_out_event_id),
        .m_status              (m_status),
        .m_last                (m_last),
        .error_count           (error_count),
        .pending               (pending),
        .checked_count         (checked_count),
        .published_count       (published_count),
        .refused_count         (refused_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: random stalls plus one long hold-off to back up the block
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending);
            $display("timed_event_queue regression: fail");
            $finish;
        end
    end

    task automatic send_request(req_t req, logic [ID_W-1:0] event_id,
                                logic [DELAY_W-1:0] delay, logic [TIME_W-1:0] now);
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_event_id <= event_id;
        s_delay_ms <= delay;
        s_now_ms   <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        request_count++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic send_random();
        int                 pick;
        logic [DELAY_W-1:0] delay;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            case ($urandom_range(0, 3))
                0:       delay = DELAY_W'($urandom_range(0, 8));
                1, 2:    delay = DELAY_W'($urandom_range(0, 500));
                default: delay = DELAY_W'($urandom);
            endcase
            send_request(REQ_ENQ, ID_W'($urandom), delay, sim_ms);
        end else if (pick < 90) begin
            sim_ms = sim_ms + TIME_W'($urandom_range(0, 250));
            send_request(REQ_TICK, ID_W'($urandom), DELAY_W'($urandom), sim_ms);
        end else if (pick < 94) begin
            send_request(REQ_CLEAR, ID_W'($urandom), DELAY_W'($urandom), $urandom);
        end else if (pick < 96) begin
            send_request(REQ_NONE, ID_W'($urandom), DELAY_W'($urandom), $urandom);
        end else begin
            send_request(($urandom_range(0, 1) == 0) ? REQ_ENQ : REQ_TICK,
                         ID_W'($urandom), DELAY_W'($urandom), $urandom);
        end
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        cfg_valid             <= 1'b1;
        cfg_instant_threshold <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [THR_W-1:0] thr;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // threshold at its reset value of one
        send_request(REQ_ENQ, 16'hFFFF, 16'h0000, 32'h0000_0000);
        send_request(REQ_ENQ, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_request(REQ_ENQ, 16'h1234, 16'h0001, 32'd100);
        // expiry wraps past the top of the time range
        send_request(REQ_ENQ, 16'hABCD, 16'hFFFF, 32'hFFFF_FFFF);
        // expiry equal to now does not fire
        send_request(REQ_TICK, 16'h0000, 16'h0000, 32'd101);
        send_request(REQ_TICK, 16'hFFFF, 16'hFFFF, 32'd102);
        send_request(REQ_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_request(REQ_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < CAPACITY; i++)
            send_request(REQ_ENQ, ID_W'(16'h0100 + i), DELAY_W'(i + 1), 32'd0);
        send_request(REQ_ENQ, 16'h7777, 16'h0005, 32'd0);
        send_request(REQ_TICK, 16'h0000, 16'h0000, 32'h0000_0020);
        send_request(REQ_ENQ, 16'h5555, 16'h000A, 32'd0);
        send_request(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(REQ_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        wait_quiet();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin thr = '0;                            send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin thr = '1;                            send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin thr = THR_W'($urandom_range(2, 600)); send_idle_pct = 0;  recv_stall_pct = 72; end
                3: begin thr = THR_RESET;                     send_idle_pct = 11; recv_stall_pct = 11; end
                4: begin thr = THR_W'($urandom);              send_idle_pct = 0;  recv_stall_pct = 0;  end
                default: begin thr = THR_W'(300);             send_idle_pct = 72; recv_stall_pct = 72; end
            endcase
            write_threshold(thr);
            sim_ms = (p == 3) ? 32'hFFFF_F000 : $urandom;
            if (p == 4) hold_armed <= 1'b1;
            repeat (PHASE_ITEMS) send_random();
            wait_quiet();
        end

        $display("covered %0d requests under %0d threshold settings, with idle, stalled and held-off channels",
                 request_count, PHASES + 1);
        $display("%0d results checked: %0d events published, %0d enqueues refused on a full store",
                 checked_count, published_count, refused_count);
        if (error_count == 0) begin
            $display("timed_event_queue regression: pass");
        end else begin
            $display("timed_event_queue regression: fail");
        end
        $finish;
    end

endmodule
